@@ hdl/otd_pkg.sv @@
package otd_pkg;

   localparam int LEVEL_W     = 13;
   localparam int LIMIT_W     = 32;
   localparam int ORIENT_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_LEVEL    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_LEVEL     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_LIMIT_SQ = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_LIMIT_SQ   = 2'd3;

   // orientation codes
   localparam logic [ORIENT_W-1:0] ST_INTERMEDIATE = 3'd0;
   localparam logic [ORIENT_W-1:0] ST_FLAT         = 3'd1;
   localparam logic [ORIENT_W-1:0] ST_OVER         = 3'd2;
   localparam logic [ORIENT_W-1:0] ST_LEFT         = 3'd3;
   localparam logic [ORIENT_W-1:0] ST_RIGHT        = 3'd4;
   localparam logic [ORIENT_W-1:0] ST_FRONT        = 3'd5;
   localparam logic [ORIENT_W-1:0] ST_BACK         = 3'd6;

   // reset values: 0.8 g, 0.5 g, 1.05^2 g^2, 1.1^2 g^2
   localparam logic [LEVEL_W-1:0] ENTER_LEVEL_RESET    = 13'd3277;
   localparam logic [LEVEL_W-1:0] EXIT_LEVEL_RESET     = 13'd2048;
   localparam logic [LIMIT_W-1:0] STILL_LIMIT_SQ_RESET = 32'd18496881;
   localparam logic [LIMIT_W-1:0] TAP_LIMIT_SQ_RESET   = 32'd20300431;

   typedef struct packed {
      logic [LEVEL_W-1:0] enter_level;
      logic [LEVEL_W-1:0] exit_level;
      logic [LIMIT_W-1:0] still_limit_sq;
      logic [LIMIT_W-1:0] tap_limit_sq;
   } cfg_type;

   // axis threshold tests, independent of the orientation state
   typedef struct packed {
      logic z_gt_en;
      logic z_lt_nen;
      logic x_lt_nen;
      logic x_gt_en;
      logic y_lt_nen;
      logic y_gt_en;
      logic z_lt_ex;
      logic z_gt_nex;
      logic x_gt_nex;
      logic x_lt_ex;
      logic y_gt_nex;
      logic y_lt_ex;
   } axis_flags_type;

   typedef struct packed {
      logic           still;
      logic           tap;
      axis_flags_type flags;
   } class_type;

   typedef struct packed {
      logic [ORIENT_W-1:0] orientation;
      logic                changed;
      logic                tap;
   } result_type;

endpackage

@@ hdl/otd_fifo.sv @@
module otd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/otd_front.sv @@
module otd_front
   import otd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  cfg_type                       cfg,
   output logic                          class_push,
   input  logic                          class_full,
   output class_type                     class_data
);

   localparam int MAG_W = 2 * SAMPLE_BITS;
   localparam int CMP_W = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;
   localparam int LW    = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;

   logic                          sample_valid_ff, sample_valid_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff, z_ff;
   logic                          accept, advance;
   logic signed [MAG_W-1:0]       sq_x, sq_y, sq_z;
   logic [MAG_W-1:0]              mag;
   logic [CMP_W-1:0]              mag_cmp;
   logic signed [LW-1:0]          x_ext, y_ext, z_ext;
   logic signed [LW-1:0]          en_pos, en_neg, ex_pos, ex_neg;

   assign req_full        = sample_valid_ff && class_full;
   assign accept          = req_push && !req_full;
   assign advance         = sample_valid_ff && !class_full;
   assign sample_valid_in = accept || (sample_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
      end else begin
         sample_valid_ff <= sample_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_accel_x;
         y_ff <= req_accel_y;
         z_ff <= req_accel_z;
      end
   end

   // squares are never negative, so their sum fits MAG_W bits unsigned
   assign sq_x    = x_ff * x_ff;
   assign sq_y    = y_ff * y_ff;
   assign sq_z    = z_ff * z_ff;
   assign mag     = MAG_W'($unsigned(sq_x)) + MAG_W'($unsigned(sq_y))
                  + MAG_W'($unsigned(sq_z));
   assign mag_cmp = CMP_W'(mag);

   assign x_ext  = {{(LW - SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
   assign y_ext  = {{(LW - SAMPLE_BITS){y_ff[SAMPLE_BITS-1]}}, y_ff};
   assign z_ext  = {{(LW - SAMPLE_BITS){z_ff[SAMPLE_BITS-1]}}, z_ff};
   assign en_pos = {{(LW - LEVEL_W){1'b0}}, cfg.enter_level};
   assign ex_pos = {{(LW - LEVEL_W){1'b0}}, cfg.exit_level};
   assign en_neg = -en_pos;
   assign ex_neg = -ex_pos;

   always_comb begin
      class_data                = '0;
      class_data.still          = (mag_cmp < CMP_W'(cfg.still_limit_sq));
      class_data.tap            = (mag_cmp > CMP_W'(cfg.tap_limit_sq));
      class_data.flags.z_gt_en  = (z_ext > en_pos);
      class_data.flags.z_lt_nen = (z_ext < en_neg);
      class_data.flags.x_lt_nen = (x_ext < en_neg);
      class_data.flags.x_gt_en  = (x_ext > en_pos);
      class_data.flags.y_lt_nen = (y_ext < en_neg);
      class_data.flags.y_gt_en  = (y_ext > en_pos);
      class_data.flags.z_lt_ex  = (z_ext < ex_pos);
      class_data.flags.z_gt_nex = (z_ext > ex_neg);
      class_data.flags.x_gt_nex = (x_ext > ex_neg);
      class_data.flags.x_lt_ex  = (x_ext < ex_pos);
      class_data.flags.y_gt_nex = (y_ext > ex_neg);
      class_data.flags.y_lt_ex  = (y_ext < ex_pos);
   end

   assign class_push = sample_valid_ff;

endmodule

@@ hdl/otd_back.sv @@
module otd_back
   import otd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       class_empty,
   output logic       class_pop,
   input  class_type  class_data,
   input  logic       result_full,
   output logic       result_push,
   output result_type result_data
);

   logic [ORIENT_W-1:0] state_ff, state_in;
   logic [ORIENT_W-1:0] cur, face;
   logic                step;
   axis_flags_type      f;

   assign step        = !class_empty && !result_full;
   assign class_pop   = step;
   assign result_push = step;
   assign f           = class_data.flags;
   assign cur         = (state_ff > ST_BACK) ? ST_INTERMEDIATE : state_ff;

   always_comb begin
      face = cur;
      case (cur)
         ST_FLAT:  face = f.z_lt_ex  ? ST_INTERMEDIATE : cur;
         ST_OVER:  face = f.z_gt_nex ? ST_INTERMEDIATE : cur;
         ST_LEFT:  face = f.x_gt_nex ? ST_INTERMEDIATE : cur;
         ST_RIGHT: face = f.x_lt_ex  ? ST_INTERMEDIATE : cur;
         ST_FRONT: face = f.y_gt_nex ? ST_INTERMEDIATE : cur;
         ST_BACK:  face = f.y_lt_ex  ? ST_INTERMEDIATE : cur;
         default: begin
            // enter priority: flat, over, left, right, front, back
            if (f.z_gt_en) begin
               face = ST_FLAT;
            end else if (f.z_lt_nen) begin
               face = ST_OVER;
            end else if (f.x_lt_nen) begin
               face = ST_LEFT;
            end else if (f.x_gt_en) begin
               face = ST_RIGHT;
            end else if (f.y_lt_nen) begin
               face = ST_FRONT;
            end else if (f.y_gt_en) begin
               face = ST_BACK;
            end else begin
               face = ST_INTERMEDIATE;
            end
         end
      endcase
   end

   always_comb begin
      state_in                = state_ff;
      result_data.orientation = cur;
      result_data.changed     = 1'b0;
      result_data.tap         = 1'b0;
      if (class_data.still) begin
         result_data.orientation = face;
         result_data.changed     = (face != cur);
      end else begin
         result_data.tap = class_data.tap;
      end
      if (step) begin
         state_in = result_data.orientation;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INTERMEDIATE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/orientation_tap_detector_top.sv @@
// Channel | Ports                                   | Beat taken when
// --------+-----------------------------------------+------------------------
// req     | req_push, req_full, req_accel_{x,y,z}   | req_push && !req_full
// rsp     | rsp_pop, rsp_empty, rsp_orientation,    | rsp_pop && !rsp_empty
//         | rsp_changed, rsp_tap                    |
// csr     | csr_valid, csr_ready, csr_index,        | csr_valid && csr_ready
//         | csr_data                                |
//
// One beat per clock sustained in both directions while neither side stalls. A
// request beat passes the sample register, classify queue and result queue in
// that order before it shows on the rsp ports. Synchronous reset empties both
// queues, returns the orientation to intermediate and loads the default levels
// and limits. Each side stalls on its own: a low rsp_pop fills the result queue,
// then the classify queue, and only then raises req_full.
// csr_ready is always high.
module orientation_tap_detector_top
   import otd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request queue side
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   // response queue side
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ORIENT_W-1:0]           rsp_orientation,
   output logic                          rsp_changed,
   output logic                          rsp_tap,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int QUEUE_DEPTH = 2;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;

   logic       class_push, class_full, class_pop, class_empty;
   class_type  class_in_data, class_out_data;
   logic       result_push, result_full;
   result_type result_in_data, result_out_data;

   // ---------------------------------------------------------------------
   // Configuration registers: take a write on every valid beat, drop the
   // bits above each register's width.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ENTER_LEVEL:    cfg_in.enter_level    = csr_data[LEVEL_W-1:0];
            CSR_EXIT_LEVEL:     cfg_in.exit_level     = csr_data[LEVEL_W-1:0];
            CSR_STILL_LIMIT_SQ: cfg_in.still_limit_sq = csr_data[LIMIT_W-1:0];
            CSR_TAP_LIMIT_SQ:   cfg_in.tap_limit_sq   = csr_data[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_level    <= ENTER_LEVEL_RESET;
         cfg_ff.exit_level     <= EXIT_LEVEL_RESET;
         cfg_ff.still_limit_sq <= STILL_LIMIT_SQ_RESET;
         cfg_ff.tap_limit_sq   <= TAP_LIMIT_SQ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front: register the sample, square and sum, compare magnitude with
   // both limits and every axis with both levels.
   // ---------------------------------------------------------------------
   otd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .cfg        (cfg_ff),
      .class_push (class_push),
      .class_full (class_full),
      .class_data (class_in_data)
   );

   // Decouple classification from the state machine.
   otd_fifo #(
      .WIDTH($bits(class_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_class_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (class_push),
      .full     (class_full),
      .push_data(class_in_data),
      .pop      (class_pop),
      .empty    (class_empty),
      .pop_data (class_out_data)
   );

   // ---------------------------------------------------------------------
   // Back: advance the orientation machine one beat per clock unless a queue stalls.
   // ---------------------------------------------------------------------
   otd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .class_empty(class_empty),
      .class_pop  (class_pop),
      .class_data (class_out_data),
      .result_full(result_full),
      .result_push(result_push),
      .result_data(result_in_data)
   );

   // Hold finished results until the consumer pops them.
   otd_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (result_push),
      .full     (result_full),
      .push_data(result_in_data),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .pop_data (result_out_data)
   );

   assign rsp_orientation = result_out_data.orientation;
   assign rsp_changed     = result_out_data.changed;
   assign rsp_tap         = result_out_data.tap;

endmodule

@@ hdl/otd_checker.sv @@
module otd_checker
   import otd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_full,
   input logic                rsp_empty,
   input logic                rsp_pop,
   input logic [ORIENT_W-1:0] rsp_orientation,
   input logic                rsp_changed,
   input logic                rsp_tap,
   input logic                csr_valid,
   input logic                csr_ready
);

   // both queues come out of reset empty and open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   // a tap beat never moves the orientation
   a_tap_no_change: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_tap |-> !rsp_changed)
      else $error("tap and changed set together");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_orientation)
         && $stable(rsp_changed) && $stable(rsp_tap))
      else $error("response changed while stalled");

   // register writes are never back-pressured
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind orientation_tap_detector_top otd_checker u_otd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_orientation(rsp_orientation),
   .rsp_changed    (rsp_changed),
   .rsp_tap        (rsp_tap),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);

@@ bench/orientation_tap_detector_top_tb.sv @@
`timescale 1ns / 1ps

module orientation_tap_detector_top_tb
   import otd_pkg::*;
();

   typedef enum logic [ORIENT_W-1:0] {
      ORIENT_INTERMEDIATE = ST_INTERMEDIATE,
      ORIENT_FLAT         = ST_FLAT,
      ORIENT_OVER         = ST_OVER,
      ORIENT_LEFT         = ST_LEFT,
      ORIENT_RIGHT        = ST_RIGHT,
      ORIENT_FRONT        = ST_FRONT,
      ORIENT_BACK         = ST_BACK
   } orient_e;

   class orientation_scoreboard;
      logic [LEVEL_W-1:0] enter_lvl;
      logic [LEVEL_W-1:0] exit_lvl;
      logic [LIMIT_W-1:0] still_lim;
      logic [LIMIT_W-1:0] tap_lim;
      orient_e            face;
      result_type         predicted_readings[$];
      int                 mismatches;
      int                 readings;
      int                 taps;
      int                 changes;
      bit                 seen[7];

      function new();
         enter_lvl = ENTER_LEVEL_RESET;
         exit_lvl  = EXIT_LEVEL_RESET;
         still_lim = STILL_LIMIT_SQ_RESET;
         tap_lim   = TAP_LIMIT_SQ_RESET;
         face      = ORIENT_INTERMEDIATE;
      endfunction

      function void apply_register(logic [CSR_INDEX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENTER_LEVEL:    enter_lvl = data[LEVEL_W-1:0];
            CSR_EXIT_LEVEL:     exit_lvl  = data[LEVEL_W-1:0];
            CSR_STILL_LIMIT_SQ: still_lim = data;
            CSR_TAP_LIMIT_SQ:   tap_lim   = data;
            default: ;
         endcase
      endfunction

      // faces hold until their axis falls back past the exit level
      function orient_e next_face(orient_e cur, int x, int y, int z);
         int en;
         int ex;
         en = enter_lvl;
         ex = exit_lvl;
         case (cur)
            ORIENT_FLAT:  return (z < ex)  ? ORIENT_INTERMEDIATE : cur;
            ORIENT_OVER:  return (z > -ex) ? ORIENT_INTERMEDIATE : cur;
            ORIENT_LEFT:  return (x > -ex) ? ORIENT_INTERMEDIATE : cur;
            ORIENT_RIGHT: return (x < ex)  ? ORIENT_INTERMEDIATE : cur;
            ORIENT_FRONT: return (y > -ex) ? ORIENT_INTERMEDIATE : cur;
            ORIENT_BACK:  return (y < ex)  ? ORIENT_INTERMEDIATE : cur;
            default: begin
               if (z > en)  return ORIENT_FLAT;
               if (z < -en) return ORIENT_OVER;
               if (x < -en) return ORIENT_LEFT;
               if (x > en)  return ORIENT_RIGHT;
               if (y < -en) return ORIENT_FRONT;
               if (y > en)  return ORIENT_BACK;
               return ORIENT_INTERMEDIATE;
            end
         endcase
      endfunction

      function void log_sample(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
         longint     mag;
         longint     still_l;
         longint     tap_l;
         orient_e    nxt;
         result_type r;
         mag     = longint'(x) * x + longint'(y) * y + longint'(z) * z;
         still_l = still_lim;
         tap_l   = tap_lim;
         r.changed = 1'b0;
         r.tap     = 1'b0;
         if (mag < still_l) begin
            nxt = next_face(face, x, y, z);
            r.changed = (nxt != face);
            face = nxt;
         end else if (mag > tap_l) begin
            r.tap = 1'b1;
         end
         r.orientation = face;
         predicted_readings.insert(predicted_readings.size(), r);
      endfunction

      function void flag(string field, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s differs, expected %0d, got %0d",
                     $time, field, want, got);
      endfunction

      function void compare_reading(logic [ORIENT_W-1:0] orient, logic changed,
                                    logic tap);
         result_type want;
         readings++;
         if (predicted_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing pending (orientation %0d)",
                        $time, orient);
            return;
         end
         want = predicted_readings.pop_front();
         if (want.orientation !== orient) flag("orientation", want.orientation, orient);
         if (want.changed !== changed)    flag("changed", want.changed, changed);
         if (want.tap !== tap)            flag("tap", want.tap, tap);
         if (tap === 1'b1) taps++;
         if (changed === 1'b1) changes++;
         if (orient < 7) seen[orient] = 1'b1;
      endfunction

      function int outstanding();
         return predicted_readings.size();
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic signed [15:0]     req_accel_x = '0;
   logic signed [15:0]     req_accel_y = '0;
   logic signed [15:0]     req_accel_z = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [ORIENT_W-1:0]    rsp_orientation;
   logic                   rsp_changed;
   logic                   rsp_tap;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int                     send_idle_pct = 36;
   int                     recv_idle_pct = 66;
   int                     cycle_count = 0;
   int                     samples_sent = 0;
   int                     settings_used = 1;

   orientation_scoreboard  board = new();

   orientation_tap_detector_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_orientation (rsp_orientation),
      .rsp_changed     (rsp_changed),
      .rsp_tap         (rsp_tap),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side at random, one decision per clock.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watch both queue sides. Check the result beat first so a beat that shows
   // up with nothing pending is caught even if a sample is taken on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            board.compare_reading(rsp_orientation, rsp_changed, rsp_tap);
         if (req_push && !req_full)
            board.log_sample(req_accel_x, req_accel_y, req_accel_z);
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Push one sample; idle first at the current rate, then hold push until the beat
   // is taken. Push stays high on return so back-to-back samples need no gap.
   task automatic send_sample(input int x, input int y, input int z);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_accel_x <= x[15:0];
      req_accel_y <= y[15:0];
      req_accel_z <= z[15:0];
      @(posedge clock);
      while (req_full) @(posedge clock);
      samples_sent++;
   endtask

   // Drop push and wait for every predicted result to come back. Always wait for the
   // clock before checking, so push never gets two assignments in one step.
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // Write all four registers back to back; only called with the block drained.
   task automatic program_levels(input logic [CSR_DATA_W-1:0] en,
                                 input logic [CSR_DATA_W-1:0] ex,
                                 input logic [CSR_DATA_W-1:0] still,
                                 input logic [CSR_DATA_W-1:0] tap);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      idx[0] = CSR_ENTER_LEVEL;    val[0] = en;
      idx[1] = CSR_EXIT_LEVEL;     val[1] = ex;
      idx[2] = CSR_STILL_LIMIT_SQ; val[2] = still;
      idx[3] = CSR_TAP_LIMIT_SQ;   val[3] = tap;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.apply_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Shape a random sample. Most carry gravity on one axis, placed on or next to
   // the current enter and exit levels so the face machine keeps moving; the rest
   // are mid-size shakes around the limits and raw full-scale noise.
   task automatic pick_sample(output int x, output int y, output int z);
      int v [3];
      int kind;
      int lvl;
      int spread;
      int en;
      int ex;
      en   = board.enter_lvl;
      ex   = board.exit_lvl;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         case ($urandom_range(0, 6))
            0:       lvl = en;
            1:       lvl = en + 1;
            2:       lvl = ex;
            3:       lvl = ex + 1;
            4:       lvl = ex - 1;
            default: lvl = $urandom_range(0, 2 * en + 64);
         endcase
         if (lvl > 32767) lvl = 32767;
         if ($urandom_range(0, 1)) lvl = -lvl;
         spread = ex / 2 + 1;
         for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 2 * spread)) - spread;
         v[$urandom_range(0, 2)] = lvl;
      end else if (kind < 8) begin
         for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 18000)) - 9000;
      end else begin
         for (int i = 0; i < 3; i++) v[i] = $signed(16'($urandom));
      end
      x = v[0];
      y = v[1];
      z = v[2];
   endtask

   initial begin
      int x;
      int y;
      int z;
      int en;
      int ex;
      logic [31:0] still;
      logic [31:0] tap;
      int seen_faces;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk every face in and out at the reset levels (enter 3277, exit 2048).
      send_sample(0, 0, 0);
      send_sample(0, 0, 4096);        // enter flat
      send_sample(0, 0, 2049);        // hold flat inside the hysteresis band
      send_sample(0, 0, 2048);        // equal to exit: no move
      send_sample(0, 0, 2047);        // leave flat
      send_sample(0, 0, 3277);        // equal to enter: no move
      send_sample(0, 0, -3278);       // enter over
      send_sample(0, 0, -2048);
      send_sample(0, 0, -2047);
      send_sample(-3278, 0, 0);       // left
      send_sample(-2047, 0, 0);
      send_sample(3278, 0, 0);        // right
      send_sample(2047, 0, 0);
      send_sample(0, -3278, 0);       // front
      send_sample(0, -2047, 0);
      send_sample(0, 3278, 0);        // back
      send_sample(0, 2047, 0);
      send_sample(4400, 0, 0);        // between the limits: nothing happens
      send_sample(32767, 32767, 32767);
      send_sample(-32768, -32768, -32768);
      drain_results();

      // Both limits at exactly 1 g squared: a magnitude on the limit passes neither
      // test. Low levels let several axes qualify at once to show the entry order.
      program_levels(1000, 500, 32'd16777216, 32'd16777216);
      send_sample(4096, 0, 0);
      send_sample(4095, 0, 0);        // right
      send_sample(4097, 0, 0);        // tap, state holds
      send_sample(0, 0, 0);
      send_sample(1500, -1500, -1500); // over wins over right and front
      send_sample(0, 0, 0);
      send_sample(-1500, 1500, 0);     // left wins over back
      send_sample(0, 0, 0);
      drain_results();

      for (int p = 0; p < 6; p++) begin
         // idling pattern: sender light and receiver heavy, then swapped, then none
         if (p < 2) begin
            send_idle_pct = 36;
            recv_idle_pct = 66;
         end else if (p < 4) begin
            send_idle_pct = 66;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case (p)
            0: begin
               // reset values, with junk above the level width that must be dropped
               en = 3277; ex = 2048;
               program_levels(32'hFFFF_0CCD, 32'hFFFF_0800, STILL_LIMIT_SQ_RESET,
                              TAP_LIMIT_SQ_RESET);
            end
            1: begin
               // crossed limits: the still test always wins, no tap can show
               program_levels(0, 0, 32'hFFFF_FFFF, 0);
            end
            2: begin
               program_levels(8191, 8191, 32'h0800_0000, 32'h1000_0000);
            end
            3: begin
               en    = $urandom_range(0, 8191);
               ex    = $urandom_range(0, en);
               still = $urandom_range(32'h0100_0000, 32'h0800_0000);
               tap   = still + $urandom_range(0, 32'h0200_0000);
               program_levels(en, ex, still, tap);
            end
            4: begin
               // every magnitude above zero is a tap; the state never moves
               program_levels(4096, 1024, 0, 0);
            end
            default: begin
               en    = $urandom_range(0, 8191);
               ex    = $urandom_range(0, 8191);
               still = $urandom_range(32'h0040_0000, 32'h0800_0000);
               tap   = $urandom_range(32'h0040_0000, 32'h0800_0000);
               program_levels(en, ex, still, tap);
            end
         endcase

         for (int n = 0; n < 62; n++) begin
            pick_sample(x, y, z);
            send_sample(x, y, z);
            // hold the sender once per phase until the block has emptied
            if (n == 30) drain_results();
         end
         drain_results();
      end

      // Let any stray result beat surface before the verdict.
      repeat (20) @(posedge clock);

      seen_faces = 0;
      foreach (board.seen[i]) seen_faces += board.seen[i];
      $display("Sent %0d samples over %0d register settings; %0d result beats checked.",
               samples_sent, settings_used, board.readings);
      $display("Saw %0d taps, %0d orientation changes, %0d of 7 orientations.",
               board.taps, board.changes, seen_faces);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
